// ----- src/cld_pkg.sv -----
// Shared types, constants and register indexes for the collinear triple detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cld_pkg;

	// Fixed field widths.
	localparam int COORD_BITS = 12;
	localparam int PORT_W = 12;
	localparam int IDX_W = 6;
	localparam int DIST_W = 26;
	localparam int COS_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int DEF_MAX_POINTS = 64;

	// Derived arithmetic widths.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int D_W = 2 * COORD_BITS + 1;
	localparam int DOT_W = 2 * COORD_BITS + 2;
	localparam int DSQ_W = 2 * DOT_W - 2;
	localparam int LEN_W = (D_W > DIST_W) ? D_W : DIST_W;
	localparam int ACM2_W = 2 * COS_W - 1;
	localparam int CA_W = COS_W + 2;
	localparam int CA2_W = 32;
	localparam int PP_W = 2 * D_W;
	localparam int PPH_W = PP_W - CA2_W;
	localparam int AXIS_SHIFT = 30;
	localparam int AX_W = 2 * COORD_BITS + AXIS_SHIFT + 2;
	localparam int DOT_SHIFT = 28;
	localparam int WIDE_W = 84;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;

	// Fixed-point reference values.
	localparam logic [COS_W-1:0] AXIS_ONE = 16'd32768;
	localparam logic [COS_W-1:0] COS_ONE = 16'd16384;

	// Reset values of the registers.
	localparam logic [DIST_W-1:0] RST_MIN_DIST = 26'd0;
	localparam logic [DIST_W-1:0] RST_MAX_DIST = 26'd33554432;
	localparam logic [COS_W-1:0] RST_AXIS_COS = 16'd29491;
	localparam logic [COS_W-1:0] RST_DOT_TOL = 16'd1638;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_COS_MIN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOT_TOLERANCE = 8'd3;

	typedef struct packed {
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} point_t;

	typedef struct packed {
		logic [DIST_W-1:0] min_dist_sq;
		logic [DIST_W-1:0] max_dist_sq;
		logic [COS_W-1:0] axis_cos_min;
		logic [COS_W-1:0] dot_tolerance;
	} cld_cfg_t;

	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic [IDX_W-1:0] third_index;
		point_t first_pt;
		point_t second_pt;
		point_t third_pt;
	} cld_result_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP_A, ST_PREP_C, ST_PREP_END, ST_I_ADDR, ST_I_CAP,
		ST_K_CHECK, ST_K_CAP, ST_D1_X, ST_D1_Y, ST_D1_SUM, ST_AXIS, ST_AXIS_CMP,
		ST_M_CHECK, ST_M_CAP, ST_D2_X, ST_D2_Y, ST_DOT_X, ST_DOT_Y, ST_DOT_SUM,
		ST_DOT_SQ, ST_PP, ST_PP_LO, ST_PP_HI, ST_DIR_CMP, ST_RESULT
	} srch_state_t;

endpackage

`default_nettype wire

// ----- src/collinear_triple_detector.sv -----
// Collinear triple detector: points load one per start beat while busy is low. A beat
// with last_point high stores its point (if room is left) and starts the search; busy
// stays high until the result. The search walks the triples (i, k, m) in order through
// one shared multiplier: a setup step, then an address and capture step per first
// index, the length and axis tests per second index, and per third index the length
// test and, for one that passes, the direction test; indexes equal to an outer one are
// skipped. The result beat (done) lasts one cycle and cannot be stalled; busy falls
// in the next cycle. Registers may be written only while busy is low.
// Depends on cld_pkg, cld_store, cld_search and cld_mul.
`default_nettype none

module collinear_triple_detector
	import cld_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [PORT_W-1:0]     point_x,
	input  wire logic [PORT_W-1:0]     point_y,
	input  wire logic                  last_point,
	output logic                       done,
	output logic                       found,
	output logic [IDX_W-1:0]           first_index,
	output logic [IDX_W-1:0]           second_index,
	output logic [IDX_W-1:0]           third_index,
	output logic [PORT_W-1:0]          first_x,
	output logic [PORT_W-1:0]          first_y,
	output logic [PORT_W-1:0]          second_x,
	output logic [PORT_W-1:0]          second_y,
	output logic [PORT_W-1:0]          third_x,
	output logic [PORT_W-1:0]          third_y,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);

	cld_cfg_t cfg_q;
	logic [CW-1:0] count_q, count_next;
	logic accept, store_en;
	logic [IW-1:0] rd_addr;
	point_t rd_data_q, wr_point;
	cld_result_t result;

	// Register write port, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_dist_sq <= RST_MIN_DIST;
			cfg_q.max_dist_sq <= RST_MAX_DIST;
			cfg_q.axis_cos_min <= RST_AXIS_COS;
			cfg_q.dot_tolerance <= RST_DOT_TOL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_DIST_SQ: cfg_q.min_dist_sq <= cfg_data[DIST_W-1:0];
				REG_MAX_DIST_SQ: cfg_q.max_dist_sq <= cfg_data[DIST_W-1:0];
				REG_AXIS_COS_MIN: cfg_q.axis_cos_min <= cfg_data[COS_W-1:0];
				REG_DOT_TOLERANCE: cfg_q.dot_tolerance <= cfg_data[COS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Point loading; points past a full set are dropped.
	assign accept = start && !busy;
	assign store_en = accept && (count_q < CW'(MAX_POINTS));
	assign count_next = count_q + CW'(store_en);
	assign wr_point.x = point_x[COORD_BITS-1:0];
	assign wr_point.y = point_y[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last_point ? '0 : count_next;
		end
	end

	cld_store #(
		.MAX_POINTS (MAX_POINTS)
	) u_store (
		.clk       (clk),
		.wr_en     (store_en),
		.wr_addr   (count_q[IW-1:0]),
		.wr_data   (wr_point),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	cld_search #(
		.MAX_POINTS (MAX_POINTS)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.srch_start (accept && last_point),
		.srch_n     (count_next),
		.cfg        (cfg_q),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data_q),
		.srch_busy  (busy),
		.res_strobe (done),
		.result     (result)
	);

	// Result fields.
	assign found = result.found;
	assign first_index = result.first_index;
	assign second_index = result.second_index;
	assign third_index = result.third_index;
	assign first_x = PORT_W'(result.first_pt.x);
	assign first_y = PORT_W'(result.first_pt.y);
	assign second_x = PORT_W'(result.second_pt.x);
	assign second_y = PORT_W'(result.second_pt.y);
	assign third_x = PORT_W'(result.third_pt.x);
	assign third_y = PORT_W'(result.third_pt.y);

endmodule

`default_nettype wire

// ----- src/cld_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on cld_pkg for the operand width.
`default_nettype none

module cld_mul
	import cld_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  mul_a,
	input  wire logic signed [MUL_W-1:0]  mul_b,
	output logic signed [PROD_W-1:0]      prod_q
);

	// One product per cycle; the sequencer picks it up in the next state.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

endmodule

`default_nettype wire

// ----- src/cld_store.sv -----
// Point memory: one write port, one read port with registered read data.
// Depends on cld_pkg for the point type.
`default_nettype none

module cld_store
	import cld_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  wire point_t                        wr_data,
	input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	output point_t                             rd_data_q
);

	point_t mem [MAX_POINTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered and valid in the cycle after the address.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- src/cld_search.sv -----
// Triple search sequencer: walks (i, k, m) in order and runs every test
// through one shared multiplier. Depends on cld_pkg and cld_mul.
`default_nettype none

module cld_search
	import cld_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int IW = $clog2(MAX_POINTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          srch_start,
	input  wire logic [CW-1:0] srch_n,
	input  wire cld_cfg_t      cfg,
	output logic [IW-1:0]      rd_addr,
	input  wire point_t        rd_data,
	output logic               srch_busy,
	output logic               res_strobe,
	output cld_result_t        result
);

	srch_state_t state_q, state_d;
	logic [CW-1:0] n_q, i_q, i_d, k_q, k_d, m_q, m_d;
	logic found_q, found_d;

	point_t pi_q, pk_q, pm_q;
	logic signed [DIFF_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [D_W-1:0] d1_q, d2_q;
	logic [2*COORD_BITS-1:0] ax2_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [DSQ_W-1:0] dsq_q;
	logic [PPH_W-1:0] pp_hi_q;
	logic [2*CA2_W-1:0] rhs_lo_q;
	logic [ACM2_W-1:0] acm2_q;
	logic [CA2_W-1:0] ca2_q;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [CA_W-1:0] c_s;
	logic [CA_W-1:0] ca;
	logic c_pos, axis_en;
	logic len1_ok, len2_ok, axis_pass, dir_pass;
	logic [AX_W-1:0] ax_lhs, ax_rhs;
	logic [WIDE_W-1:0] dir_lhs, dir_rhs;

	function automatic logic len_ok(input logic [D_W-1:0] d, input cld_cfg_t c);
		return (d != '0) && (LEN_W'(d) >= LEN_W'(c.min_dist_sq)) &&
			(LEN_W'(d) <= LEN_W'(c.max_dist_sq));
	endfunction

	cld_mul u_mul (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.prod_q (prod_q)
	);

	// Thresholds derived from the registers.
	assign c_s = signed'(CA_W'(COS_ONE)) - signed'(CA_W'(cfg.dot_tolerance));
	assign ca = c_s[CA_W-1] ? CA_W'(-c_s) : CA_W'(c_s);
	assign c_pos = !c_s[CA_W-1] && (c_s != '0);
	assign axis_en = cfg.axis_cos_min <= AXIS_ONE;

	// Tests evaluated from the latest product.
	assign len1_ok = len_ok(d1_q, cfg);
	assign len2_ok = len_ok(d2_q, cfg);
	assign ax_lhs = AX_W'(ax2_q) << AXIS_SHIFT;
	assign ax_rhs = AX_W'(prod_q[AX_W-1:0]);
	assign axis_pass = len1_ok && axis_en && (ax_lhs >= ax_rhs);
	assign dir_lhs = WIDE_W'(dsq_q) << DOT_SHIFT;
	assign dir_rhs = WIDE_W'(rhs_lo_q) +
		(WIDE_W'(prod_q[PPH_W+CA2_W-1:0]) << CA2_W);

	always_comb begin
		if (c_pos) begin
			dir_pass = !dot_q[DOT_W-1] && (dot_q != '0) && (dir_lhs >= dir_rhs);
		end else begin
			dir_pass = !dot_q[DOT_W-1] || (dir_lhs <= dir_rhs);
		end
	end

	// Multiplier operand selection per step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PREP_A: begin
				mul_a = signed'(MUL_W'(cfg.axis_cos_min));
				mul_b = signed'(MUL_W'(cfg.axis_cos_min));
			end
			ST_PREP_C: begin
				mul_a = signed'(MUL_W'(ca));
				mul_b = signed'(MUL_W'(ca));
			end
			ST_D1_X: begin
				mul_a = MUL_W'(x1_q);
				mul_b = MUL_W'(x1_q);
			end
			ST_D1_Y: begin
				mul_a = MUL_W'(y1_q);
				mul_b = MUL_W'(y1_q);
			end
			ST_AXIS: begin
				mul_a = signed'(MUL_W'(acm2_q));
				mul_b = signed'(MUL_W'(d1_q));
			end
			ST_D2_X: begin
				mul_a = MUL_W'(x2_q);
				mul_b = MUL_W'(x2_q);
			end
			ST_D2_Y: begin
				mul_a = MUL_W'(y2_q);
				mul_b = MUL_W'(y2_q);
			end
			ST_DOT_X: begin
				mul_a = MUL_W'(x1_q);
				mul_b = MUL_W'(x2_q);
			end
			ST_DOT_Y: begin
				mul_a = MUL_W'(y1_q);
				mul_b = MUL_W'(y2_q);
			end
			ST_DOT_SQ: begin
				mul_a = MUL_W'(dot_q);
				mul_b = MUL_W'(dot_q);
			end
			ST_PP: begin
				mul_a = signed'(MUL_W'(d1_q));
				mul_b = signed'(MUL_W'(d2_q));
			end
			ST_PP_LO: begin
				mul_a = signed'(MUL_W'(prod_q[CA2_W-1:0]));
				mul_b = signed'(MUL_W'(ca2_q));
			end
			ST_PP_HI: begin
				mul_a = signed'(MUL_W'(pp_hi_q));
				mul_b = signed'(MUL_W'(ca2_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Read address: the counter of the loop that is fetching.
	always_comb begin
		unique case (state_q)
			ST_I_ADDR: rd_addr = i_q[IW-1:0];
			ST_K_CHECK: rd_addr = k_q[IW-1:0];
			default: rd_addr = m_q[IW-1:0];
		endcase
	end

	// Next state and loop counters.
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		k_d = k_q;
		m_d = m_q;
		found_d = found_q;
		unique case (state_q)
			ST_IDLE: begin
				if (srch_start) begin
					state_d = ST_PREP_A;
					found_d = 1'b0;
				end
			end
			ST_PREP_A: state_d = ST_PREP_C;
			ST_PREP_C: state_d = ST_PREP_END;
			ST_PREP_END: begin
				i_d = '0;
				state_d = ST_I_ADDR;
			end
			ST_I_ADDR: begin
				state_d = (i_q == n_q) ? ST_RESULT : ST_I_CAP;
			end
			ST_I_CAP: begin
				k_d = '0;
				state_d = ST_K_CHECK;
			end
			ST_K_CHECK: begin
				if (k_q == n_q) begin
					i_d = i_q + 1'b1;
					state_d = ST_I_ADDR;
				end else if (k_q == i_q) begin
					k_d = k_q + 1'b1;
				end else begin
					state_d = ST_K_CAP;
				end
			end
			ST_K_CAP: state_d = ST_D1_X;
			ST_D1_X: state_d = ST_D1_Y;
			ST_D1_Y: state_d = ST_D1_SUM;
			ST_D1_SUM: state_d = ST_AXIS;
			ST_AXIS: state_d = ST_AXIS_CMP;
			ST_AXIS_CMP: begin
				if (axis_pass) begin
					m_d = '0;
					state_d = ST_M_CHECK;
				end else begin
					k_d = k_q + 1'b1;
					state_d = ST_K_CHECK;
				end
			end
			ST_M_CHECK: begin
				if (m_q == n_q) begin
					k_d = k_q + 1'b1;
					state_d = ST_K_CHECK;
				end else if ((m_q == i_q) || (m_q == k_q)) begin
					m_d = m_q + 1'b1;
				end else begin
					state_d = ST_M_CAP;
				end
			end
			ST_M_CAP: state_d = ST_D2_X;
			ST_D2_X: state_d = ST_D2_Y;
			ST_D2_Y: state_d = ST_DOT_X;
			ST_DOT_X: state_d = ST_DOT_Y;
			ST_DOT_Y: state_d = ST_DOT_SUM;
			ST_DOT_SUM: begin
				if (len2_ok) begin
					state_d = ST_DOT_SQ;
				end else begin
					m_d = m_q + 1'b1;
					state_d = ST_M_CHECK;
				end
			end
			ST_DOT_SQ: state_d = ST_PP;
			ST_PP: state_d = ST_PP_LO;
			ST_PP_LO: state_d = ST_PP_HI;
			ST_PP_HI: state_d = ST_DIR_CMP;
			ST_DIR_CMP: begin
				if (dir_pass) begin
					found_d = 1'b1;
					state_d = ST_RESULT;
				end else begin
					m_d = m_q + 1'b1;
					state_d = ST_M_CHECK;
				end
			end
			ST_RESULT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			i_q <= '0;
			k_q <= '0;
			m_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			k_q <= k_d;
			m_q <= m_d;
			found_q <= found_d;
			if ((state_q == ST_IDLE) && srch_start) begin
				n_q <= srch_n;
			end
		end
	end

	// Datapath registers, loaded step by step from memory and product.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_PREP_C: acm2_q <= prod_q[ACM2_W-1:0];
			ST_PREP_END: ca2_q <= prod_q[CA2_W-1:0];
			ST_I_CAP: pi_q <= rd_data;
			ST_K_CAP: begin
				pk_q <= rd_data;
				x1_q <= signed'(DIFF_W'(rd_data.x)) - signed'(DIFF_W'(pi_q.x));
				y1_q <= signed'(DIFF_W'(rd_data.y)) - signed'(DIFF_W'(pi_q.y));
			end
			ST_D1_Y: begin
				d1_q <= prod_q[D_W-1:0];
				ax2_q <= prod_q[2*COORD_BITS-1:0];
			end
			ST_D1_SUM: d1_q <= d1_q + prod_q[D_W-1:0];
			ST_M_CAP: begin
				pm_q <= rd_data;
				x2_q <= signed'(DIFF_W'(rd_data.x)) - signed'(DIFF_W'(pk_q.x));
				y2_q <= signed'(DIFF_W'(rd_data.y)) - signed'(DIFF_W'(pk_q.y));
			end
			ST_D2_Y: d2_q <= prod_q[D_W-1:0];
			ST_DOT_X: d2_q <= d2_q + prod_q[D_W-1:0];
			ST_DOT_Y: dot_q <= DOT_W'(prod_q);
			ST_DOT_SUM: dot_q <= dot_q + DOT_W'(prod_q);
			ST_PP: dsq_q <= prod_q[DSQ_W-1:0];
			ST_PP_LO: pp_hi_q <= prod_q[PP_W-1:CA2_W];
			ST_PP_HI: rhs_lo_q <= prod_q[2*CA2_W-1:0];
			default: begin
			end
		endcase
	end

	// Result beat, zeroed when nothing was found.
	assign srch_busy = state_q != ST_IDLE;
	assign res_strobe = state_q == ST_RESULT;

	always_comb begin
		result = '0;
		if (found_q) begin
			result.found = 1'b1;
			result.first_index = IDX_W'(i_q);
			result.second_index = IDX_W'(k_q);
			result.third_index = IDX_W'(m_q);
			result.first_pt = pi_q;
			result.second_pt = pk_q;
			result.third_pt = pm_q;
		end
	end

endmodule

`default_nettype wire

// ----- bench/collinear_triple_detector_test.sv -----
// Self-checking regression for the collinear triple detector: point sets with random idling
// across several register settings, each result checked against an independent search.
// Depends on cld_pkg and the collinear_triple_detector RTL.
`timescale 1ns / 100ps

module collinear_triple_detector_test;
	import cld_pkg::*;

	// Tracks the loaded point set and the registers, and holds the triples still to come.
	class triple_scoreboard;
		point_t pts [DEF_MAX_POINTS];
		int unsigned n_pts;
		logic [DIST_W-1:0] min_d;
		logic [DIST_W-1:0] max_d;
		logic [COS_W-1:0] axis_min;
		logic [COS_W-1:0] tol;
		cld_result_t pending [$];
		int errors;

		function new();
			n_pts = 0;
			min_d = RST_MIN_DIST;
			max_d = RST_MAX_DIST;
			axis_min = RST_AXIS_COS;
			tol = RST_DOT_TOL;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MIN_DIST_SQ: min_d = data[DIST_W-1:0];
				REG_MAX_DIST_SQ: max_d = data[DIST_W-1:0];
				REG_AXIS_COS_MIN: axis_min = data[COS_W-1:0];
				REG_DOT_TOLERANCE: tol = data[COS_W-1:0];
				default: ;
			endcase
		endfunction

		function bit length_pass(longint d);
			return d != 0 && d >= longint'(min_d) && d <= longint'(max_d);
		endfunction

		function bit axis_pass(longint dx, longint d1);
			longint acm;
			acm = longint'(axis_min);
			if (axis_min > AXIS_ONE) return 0;
			return ((dx * dx) << AXIS_SHIFT) >= acm * acm * d1;
		endfunction

		// Compare 16384*dot against c*sqrt(d1*d2) by squaring, keeping track of signs.
		function bit direction_pass(longint dot, longint d1, longint d2);
			longint c;
			logic [127:0] lhs;
			logic [127:0] rhs;
			logic [127:0] cc;
			c = 16384 - longint'(tol);
			lhs = dot * dot;
			lhs = lhs << DOT_SHIFT;
			rhs = d1 * d2;
			cc = c * c;
			rhs = rhs * cc;
			if (c <= 0) return dot >= 0 || lhs <= rhs;
			return dot > 0 && lhs >= rhs;
		endfunction

		// First qualifying triple in lexicographic order of (i, k, m).
		function cld_result_t find_triple();
			cld_result_t r;
			longint x1, y1, x2, y2, d1, d2;
			r = '0;
			for (int i = 0; i < n_pts; i++) begin
				for (int k = 0; k < n_pts; k++) begin
					if (k == i) continue;
					x1 = longint'(pts[k].x) - longint'(pts[i].x);
					y1 = longint'(pts[k].y) - longint'(pts[i].y);
					d1 = x1 * x1 + y1 * y1;
					if (!length_pass(d1) || !axis_pass(x1, d1)) continue;
					for (int m = 0; m < n_pts; m++) begin
						if (m == i || m == k) continue;
						x2 = longint'(pts[m].x) - longint'(pts[k].x);
						y2 = longint'(pts[m].y) - longint'(pts[k].y);
						d2 = x2 * x2 + y2 * y2;
						if (!length_pass(d2)) continue;
						if (!direction_pass(x1 * x2 + y1 * y2, d1, d2)) continue;
						r.found = 1'b1;
						r.first_index = i[IDX_W-1:0];
						r.second_index = k[IDX_W-1:0];
						r.third_index = m[IDX_W-1:0];
						r.first_pt = pts[i];
						r.second_pt = pts[k];
						r.third_pt = pts[m];
						return r;
					end
				end
			end
			return r;
		endfunction

		// One accepted point beat; the last one of a set queues the search result.
		function void note_point(logic [PORT_W-1:0] x, logic [PORT_W-1:0] y, logic last);
			if (n_pts < DEF_MAX_POINTS) begin
				pts[n_pts] = '{y: y, x: x};
				n_pts++;
			end
			if (!last) return;
			pending.push_back(find_triple());
			n_pts = 0;
		endfunction

		function void compare(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(cld_result_t got);
			cld_result_t e;
			if (pending.size() == 0) begin
				$error("result beat with no triple expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			compare("found", e.found, got.found);
			compare("first_index", e.first_index, got.first_index);
			compare("second_index", e.second_index, got.second_index);
			compare("third_index", e.third_index, got.third_index);
			compare("first_x", e.first_pt.x, got.first_pt.x);
			compare("first_y", e.first_pt.y, got.first_pt.y);
			compare("second_x", e.second_pt.x, got.second_pt.x);
			compare("second_y", e.second_pt.y, got.second_pt.y);
			compare("third_x", e.third_pt.x, got.third_pt.x);
			compare("third_y", e.third_pt.y, got.third_pt.y);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [PORT_W-1:0] point_x;
	logic [PORT_W-1:0] point_y;
	logic last_point;
	logic done;
	logic found;
	logic [IDX_W-1:0] first_index, second_index, third_index;
	logic [PORT_W-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	triple_scoreboard board;
	bit idling_on;

	collinear_triple_detector dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Results are stable across the low phase of the clock, so sample them there.
	always @(negedge clk) begin
		cld_result_t got;
		if (arst_n && done) begin
			got.found = found;
			got.first_index = first_index;
			got.second_index = second_index;
			got.third_index = third_index;
			got.first_pt = '{y: first_y, x: first_x};
			got.second_pt = '{y: second_y, x: second_x};
			got.third_pt = '{y: third_y, x: third_x};
			board.check(got);
		end
	end

	// Drives one point beat from a rising edge; returns at the edge that accepts it, or after an idle stretch.
	task automatic send_point(int x, int y, bit last);
		start <= 1'b1;
		point_x <= x[PORT_W-1:0];
		point_y <= y[PORT_W-1:0];
		last_point <= last;
		@(negedge clk);
		while (busy) @(negedge clk);
		board.note_point(x[PORT_W-1:0], y[PORT_W-1:0], last);
		@(posedge clk);
		if (idling_on && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// One register beat; the channel then rests idle before the task returns.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		board.write_reg(idx, data);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the sender off until every expected result has come and the block has settled.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(int unsigned mn, int unsigned mx, int unsigned acm,
			int unsigned tl);
		drain();
		write_reg(REG_MIN_DIST_SQ, mn);
		write_reg(REG_MAX_DIST_SQ, mx);
		write_reg(REG_AXIS_COS_MIN, acm);
		write_reg(REG_DOT_TOLERANCE, tl);
	endtask

	function automatic int clamp_coord(int v);
		return v < 0 ? 0 : (v > 4095 ? 4095 : v);
	endfunction

	// One point set: mostly near-horizontal runs with jitter, some scattered noise.
	task automatic send_random_set();
		int n, bx, by, sx, sy, jit, roll;
		bit scatter;
		roll = $urandom_range(99);
		n = roll < 5 ? $urandom_range(1, 2) : (roll < 8 ? $urandom_range(8, 16)
			: $urandom_range(3, 7));
		scatter = $urandom_range(99) < 30;
		bx = $urandom_range(4095);
		by = $urandom_range(4095);
		sx = $urandom_range(1, 400) * ($urandom_range(1) ? 1 : -1);
		sy = $urandom_range(0, 60) - 30;
		jit = $urandom_range(0, 3);
		for (int j = 0; j < n; j++) begin
			if (scatter || $urandom_range(9) == 0)
				send_point($urandom_range(4095), $urandom_range(4095), j == n - 1);
			else
				send_point(clamp_coord(bx + j * sx + $urandom_range(0, 2 * jit) - jit),
					clamp_coord(by + j * sy + $urandom_range(0, 2 * jit) - jit), j == n - 1);
		end
	endtask

	initial begin
		int unsigned items_sent;
		board = new();
		idling_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		last_point = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed sets under the reset register values.
		send_point(0, 0, 0);
		send_point(100, 0, 0);
		send_point(200, 0, 1);
		send_point(4095, 4095, 0);
		send_point(0, 4095, 0);
		send_point(4095, 0, 1);
		// Fewer than three points.
		send_point(7, 9, 1);
		send_point(10, 10, 0);
		send_point(20, 10, 1);
		// Vertical line fails the axis test; repeated points give zero-length steps.
		send_point(500, 100, 0);
		send_point(500, 300, 0);
		send_point(500, 600, 1);
		send_point(2730, 1365, 0);
		send_point(2730, 1365, 0);
		send_point(2730, 1365, 1);
		// Overfull set: points past the store limit are dropped, last one included.
		for (int j = 0; j < DEF_MAX_POINTS + 2; j++)
			send_point(j < 3 ? 1000 + 50 * j : $urandom_range(4095),
				j < 3 ? 2000 : $urandom_range(4095), j == DEF_MAX_POINTS + 1);

		// Register settings, extremes among them; one stretch runs without idling.
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: configure(0, 33554432, 29491, 1638);
				1: configure(0, 32'h3ffffff, 0, 0);
				2: configure(100, 40000, 32768, 1638);
				3: configure(0, 0, 29491, 1638);
				4: configure(50000, 100, 29491, 16384);
				5: configure(0, 33554432, 65535, 16384);
				6: configure(0, 32'h3ffffff, 16000, 32768);
				7: configure(1000, 90000, 20000, 65535);
				default: configure($urandom_range(0, 3000), $urandom_range(20000, 400000),
					$urandom_range(0, 32768), $urandom_range(0, 20000));
			endcase
			if (phase == 0) write_reg(8'hff, $urandom);
			idling_on = phase != 2;
			items_sent = 0;
			while (items_sent < 85) begin
				send_random_set();
				items_sent += 5;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("collinear_triple_detector regression: pass");
		else
			$display("collinear_triple_detector regression: fail");
		$finish;
	end

	initial begin
		#200000000;
		$display("collinear_triple_detector regression: fail");
		$finish;
	end

endmodule
